### sv/rad_pkg.sv
// rad_pkg: shared constants, types and command codes for rational_add_divide_reduce
// no dependencies
package rad_pkg;
    localparam int FIELD_BITS      = 31;
    localparam int OP_BITS         = 2;
    localparam int VALUE_BITS_DEF  = 31;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DIV    = 2'd1;
    localparam logic [1:0] OP_REDUCE = 2'd2;

    // datapath commands
    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_LOAD    = 4'd1;  // latch operands, check range
    localparam logic [3:0] CMD_GCD_AB  = 4'd2;  // x=ad, y=bd
    localparam logic [3:0] CMD_GCD_NUM = 4'd3;  // x=rn, y=rd
    localparam logic [3:0] CMD_GCD_K   = 4'd4;  // x=rn, y=k
    localparam logic [3:0] CMD_STEP    = 4'd5;  // not decoded by rad_datapath
    localparam logic [3:0] CMD_START   = 4'd6;  // start unit with selected operands
    localparam logic [3:0] CMD_SAVE    = 4'd7;  // store unit result
    localparam logic [3:0] CMD_PLAIN   = 4'd8;  // plain sum over equal denominators

    // operand / destination selection for shared divide and multiply units
    localparam logic [3:0] SEL_L_DIV_G    = 4'd0;  // t = ad / g
    localparam logic [3:0] SEL_L_MUL      = 4'd1;  // l = t * bd
    localparam logic [3:0] SEL_LA         = 4'd2;  // t = l / ad
    localparam logic [3:0] SEL_P          = 4'd3;  // p = an * t
    localparam logic [3:0] SEL_LB         = 4'd4;  // t = l / bd
    localparam logic [3:0] SEL_Q          = 4'd5;  // q = bn * t, then rn = p + q, rd = l
    localparam logic [3:0] SEL_RN_DIV_G   = 4'd6;  // rn = rn / g
    localparam logic [3:0] SEL_RD_DIV_G   = 4'd7;  // rd = rd / g
    localparam logic [3:0] SEL_K_DIV_G    = 4'd8;  // t = k / g
    localparam logic [3:0] SEL_RD_MUL     = 4'd9;  // rd = rd * t

    typedef struct packed {
        logic [3:0] cmd;
        logic [3:0] sel;
        logic       is_mul;
    } rad_cmd_t;

    typedef struct packed {
        logic       bad;
        logic       gcd_done;
        logic       unit_done;
        logic       den_eq;
        logic       rn_zero;
        logic [1:0] op;
    } rad_stat_t;

    // request and result payloads
    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [FIELD_BITS-1:0] a_num;
        logic [FIELD_BITS-1:0] a_den;
        logic [FIELD_BITS-1:0] b_num;
        logic [FIELD_BITS-1:0] b_den;
        logic [FIELD_BITS-1:0] divisor;
    } frac_req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] res_num;
        logic [FIELD_BITS-1:0] res_den;
        logic                  overflow;
    } frac_res_t;
endpackage

### sv/rad_if.sv
// rad_if: valid/ready channel carrying one request of generic payload
// depends on nothing
interface rad_if #(parameter type PAYLOAD_T = logic) (input logic clk);
    logic     valid;
    logic     ready;
    PAYLOAD_T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/rad_datapath.sv
// rad_datapath: registers, gcd unit (each remainder computed by the subtract-shift
// divider) and shared bit-serial divider and multiplier; depends on rad_pkg
module rad_datapath import rad_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rad_cmd_t              cmd,
    output rad_stat_t             stat,
    input  logic [OP_BITS-1:0]    in_op,
    input  logic [FIELD_BITS-1:0] in_an,
    input  logic [FIELD_BITS-1:0] in_ad,
    input  logic [FIELD_BITS-1:0] in_bn,
    input  logic [FIELD_BITS-1:0] in_bd,
    input  logic [FIELD_BITS-1:0] in_k,
    output logic [FIELD_BITS-1:0] res_num,
    output logic [FIELD_BITS-1:0] res_den
);
    localparam int W  = VALUE_BITS;
    localparam int CW = $clog2(W + 1);

    logic [OP_BITS-1:0] op_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg, k_reg;
    logic [W-1:0] rn_reg, rd_reg, g_reg, t_reg, l_reg, p_reg;
    logic         bad_reg;

    // gcd: x, y; each remainder computed by the divide unit
    logic [W-1:0] gx_reg, gy_reg;
    logic         gact_reg, gdone_reg;

    // shared unit: restoring divider or shift-add multiplier
    logic [W-1:0] ua_reg, ub_reg, uq_reg;   // dividend/multiplicand, divisor/multiplier
    logic [W:0]   urem_reg;
    logic [W:0]   uacc_reg;                 // multiply accumulator; overflow is tracked in uovf_reg
    logic         uovf_reg, umul_reg, ubusy_reg, udone_reg, ugcd_reg;
    logic [CW-1:0] ucnt_reg;
    logic [3:0]   usel_reg;

    // the field inputs are 31 bits; W may differ
    function automatic logic [W-1:0] fit(input logic [FIELD_BITS-1:0] v, output logic over);
        logic [63:0] wide;
        wide = 64'(v);
        over = (W < FIELD_BITS) && ((wide >> W) != 64'd0);
        return W'(wide);
    endfunction

    logic [W-1:0] an_f, ad_f, bn_f, bd_f, k_f;
    logic         an_o, ad_o, bn_o, bd_o, k_o;
    always_comb
    begin
        an_f = fit(in_an, an_o);
        ad_f = fit(in_ad, ad_o);
        bn_f = fit(in_bn, bn_o);
        bd_f = fit(in_bd, bd_o);
        k_f  = fit(in_k, k_o);
    end

    logic load_bad;
    always_comb
    begin
        load_bad = an_o || ad_o || (in_ad == '0);
        if (in_op == OP_ADD)
            load_bad = load_bad || bn_o || bd_o || (in_bd == '0);
        else if (in_op == OP_DIV)
            load_bad = load_bad || k_o || (in_k == '0);
    end

    // operand selection for unit start
    logic [W-1:0] sa, sb;
    always_comb
    begin
        sa = '0;
        sb = '1;
        case (cmd.sel)
            SEL_L_DIV_G:  begin sa = ad_reg; sb = g_reg;  end
            SEL_L_MUL:    begin sa = t_reg;  sb = bd_reg; end
            SEL_LA:       begin sa = l_reg;  sb = ad_reg; end
            SEL_P:        begin sa = an_reg; sb = t_reg;  end
            SEL_LB:       begin sa = l_reg;  sb = bd_reg; end
            SEL_Q:        begin sa = bn_reg; sb = t_reg;  end
            SEL_RN_DIV_G: begin sa = rn_reg; sb = g_reg;  end
            SEL_RD_DIV_G: begin sa = rd_reg; sb = g_reg;  end
            SEL_K_DIV_G:  begin sa = k_reg;  sb = g_reg;  end
            SEL_RD_MUL:   begin sa = rd_reg; sb = t_reg;  end
            default:      begin sa = '0;     sb = '1;     end
        endcase
    end

    // divider step
    logic [W:0]   trial;
    logic [W:0]   rem_sh;
    always_comb
    begin
        rem_sh = {urem_reg[W-1:0], ua_reg[W-1]};
        trial  = rem_sh - {1'b0, ub_reg};
    end

    // multiplier step (msb first): acc = 2*acc + (bit ? a : 0)
    logic [W+1:0] macc;
    always_comb
    begin
        macc = {uacc_reg, 1'b0} + ((ub_reg[W-1]) ? {2'b00, ua_reg} : '0);
    end

    logic [W:0] sum_pq;
    assign sum_pq = {1'b0, p_reg} + {1'b0, uacc_reg[W-1:0]};
    logic [W:0] sum_ab;
    assign sum_ab = {1'b0, an_reg} + {1'b0, bn_reg};

    logic [W-1:0] ures;
    assign ures = umul_reg ? uacc_reg[W-1:0] : uq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ubusy_reg <= 1'b0;
            udone_reg <= 1'b0;
            gact_reg  <= 1'b0;
            gdone_reg <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            gdone_reg <= gact_reg && !ubusy_reg && !udone_reg && (gy_reg == '0);
            udone_reg <= ubusy_reg && (ucnt_reg == CW'(1)) && !ugcd_reg;
            // gcd: when y==0 finish, else start a divide for x % y
            if (gact_reg && !ubusy_reg && !udone_reg)
            begin
                if (gy_reg == '0)
                begin
                    gact_reg  <= 1'b0;
                    g_reg     <= gx_reg;
                end
                else
                begin
                    ua_reg    <= gx_reg;
                    ub_reg    <= gy_reg;
                    urem_reg  <= '0;
                    uq_reg    <= '0;
                    umul_reg  <= 1'b0;
                    ucnt_reg  <= CW'(W);
                    ubusy_reg <= 1'b1;
                    ugcd_reg  <= 1'b1;
                end
            end
            if (ubusy_reg)
            begin
                if (umul_reg)
                begin
                    if (macc[W+1:W] != 2'b00 || uacc_reg[W])
                        uovf_reg <= 1'b1;
                    uacc_reg <= {1'b0, macc[W-1:0]};
                    ub_reg   <= {ub_reg[W-2:0], 1'b0};
                end
                else
                begin
                    ua_reg <= {ua_reg[W-2:0], 1'b0};
                    if (!trial[W])
                    begin
                        urem_reg <= trial;
                        uq_reg   <= {uq_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        urem_reg <= rem_sh;
                        uq_reg   <= {uq_reg[W-2:0], 1'b0};
                    end
                end
                ucnt_reg <= ucnt_reg - 1'b1;
                if (ucnt_reg == CW'(1))
                begin
                    ubusy_reg <= 1'b0;
                    if (ugcd_reg)
                    begin
                        // new pair (y, x mod y); remainder comes from this last step
                        gx_reg   <= gy_reg;
                        gy_reg   <= (!trial[W]) ? trial[W-1:0] : rem_sh[W-1:0];
                        ugcd_reg <= 1'b0;
                    end
                end
            end
            case (cmd.cmd)
                CMD_LOAD:
                begin
                    op_reg  <= in_op;
                    an_reg  <= an_f;
                    ad_reg  <= ad_f;
                    bn_reg  <= bn_f;
                    bd_reg  <= bd_f;
                    k_reg   <= k_f;
                    rn_reg  <= an_f;
                    rd_reg  <= ad_f;
                    bad_reg <= load_bad;
                end
                CMD_GCD_AB:
                begin
                    gx_reg <= ad_reg; gy_reg <= bd_reg; gact_reg <= 1'b1;
                end
                CMD_GCD_NUM:
                begin
                    gx_reg <= rn_reg; gy_reg <= rd_reg; gact_reg <= 1'b1;
                end
                CMD_GCD_K:
                begin
                    gx_reg <= rn_reg; gy_reg <= k_reg; gact_reg <= 1'b1;
                end
                CMD_START:
                begin
                    ua_reg    <= sa;
                    ub_reg    <= sb;
                    urem_reg  <= '0;
                    uq_reg    <= '0;
                    uacc_reg  <= '0;
                    uovf_reg  <= 1'b0;
                    umul_reg  <= cmd.is_mul;
                    usel_reg  <= cmd.sel;
                    ucnt_reg  <= CW'(W);
                    ubusy_reg <= 1'b1;
                    ugcd_reg  <= 1'b0;
                end
                CMD_SAVE:
                begin
                    bad_reg <= bad_reg || (umul_reg && uovf_reg) ||
                               ((usel_reg == SEL_Q) && sum_pq[W]);
                    case (usel_reg)
                        SEL_L_MUL:    l_reg  <= ures;
                        SEL_P:        p_reg  <= ures;
                        SEL_Q:
                        begin
                            rd_reg <= l_reg;
                            rn_reg <= sum_pq[W-1:0];
                        end
                        SEL_RN_DIV_G: rn_reg <= ures;
                        SEL_RD_DIV_G: rd_reg <= ures;
                        SEL_RD_MUL:   rd_reg <= ures;
                        default:      t_reg  <= ures;
                    endcase
                end
                CMD_PLAIN:
                begin
                    rn_reg <= sum_ab[W-1:0];
                    rd_reg <= ad_reg;
                    if (sum_ab[W])
                        bad_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign stat.bad       = bad_reg;
    assign stat.gcd_done  = gdone_reg;
    assign stat.unit_done = udone_reg;
    assign stat.den_eq    = (ad_reg == bd_reg);
    assign stat.rn_zero   = (rn_reg == '0);
    assign stat.op        = op_reg;

    // final value: 0/1 on fault or zero numerator, then fit to field width
    logic [63:0] rn_w, rd_w;
    always_comb
    begin
        rn_w = 64'(rn_reg);
        rd_w = 64'(rd_reg);
        if (bad_reg || rn_reg == '0)
        begin
            rn_w = 64'd0;
            rd_w = 64'd1;
        end
        res_num = rn_w[FIELD_BITS-1:0];
        res_den = rd_w[FIELD_BITS-1:0];
    end
endmodule

### sv/rad_ctrl.sv
// rad_ctrl: sequencer that walks one request through load, gcd, divides and
// multiplies; depends on rad_pkg
module rad_ctrl import rad_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  rad_stat_t stat,
    output rad_cmd_t  cmd
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHECK  = 5'd1;
    localparam logic [4:0] S_GAB    = 5'd2;
    localparam logic [4:0] S_U_LDG  = 5'd3;
    localparam logic [4:0] S_U_LMUL = 5'd4;
    localparam logic [4:0] S_U_LA   = 5'd5;
    localparam logic [4:0] S_U_P    = 5'd6;
    localparam logic [4:0] S_U_LB   = 5'd7;
    localparam logic [4:0] S_U_Q    = 5'd8;
    localparam logic [4:0] S_RED    = 5'd9;
    localparam logic [4:0] S_GRED   = 5'd10;
    localparam logic [4:0] S_U_RN   = 5'd11;
    localparam logic [4:0] S_U_RD   = 5'd12;
    localparam logic [4:0] S_AFTER  = 5'd13;
    localparam logic [4:0] S_GK     = 5'd14;
    localparam logic [4:0] S_U_RNK  = 5'd15;
    localparam logic [4:0] S_U_KG   = 5'd16;
    localparam logic [4:0] S_U_RDM  = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;
    localparam logic [4:0] S_PLAIN  = 5'd19;

    logic [4:0] state_reg, state_next;
    logic       run_reg, run_next;   // unit started and waiting
    logic       post_reg, post_next; // reduction done: divide step follows

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // next-state and command decode; unit states start the unit, then wait for done
    always_comb
    begin
        state_next = state_reg;
        run_next   = run_reg;
        post_next  = post_reg;
        cmd        = '{cmd: CMD_NONE, sel: SEL_L_DIV_G, is_mul: 1'b0};
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.cmd    = CMD_LOAD;
                    state_next = S_CHECK;
                end
            S_CHECK:
                if (stat.bad)
                    state_next = S_OUT;
                else if (stat.op == OP_ADD)
                    state_next = stat.den_eq ? S_PLAIN : S_GAB;
                else
                begin
                    post_next  = (stat.op == OP_DIV);
                    state_next = S_RED;
                end
            S_PLAIN:
            begin
                cmd.cmd    = CMD_PLAIN;
                post_next  = 1'b0;
                state_next = S_RED;
            end
            S_GAB:
                if (!run_reg)
                begin
                    cmd.cmd  = CMD_GCD_AB;
                    run_next = 1'b1;
                end
                else if (stat.gcd_done)
                begin
                    run_next   = 1'b0;
                    state_next = S_U_LDG;
                end
            S_RED:
                if (stat.bad || stat.rn_zero)
                    state_next = S_OUT;
                else
                    state_next = S_GRED;
            S_GRED:
                if (!run_reg)
                begin
                    cmd.cmd  = CMD_GCD_NUM;
                    run_next = 1'b1;
                end
                else if (stat.gcd_done)
                begin
                    run_next   = 1'b0;
                    state_next = S_U_RN;
                end
            S_AFTER:
                state_next = post_reg ? S_GK : S_OUT;
            S_GK:
                if (!run_reg)
                begin
                    cmd.cmd  = CMD_GCD_K;
                    run_next = 1'b1;
                end
                else if (stat.gcd_done)
                begin
                    run_next   = 1'b0;
                    state_next = S_U_RNK;
                end
            S_U_LDG, S_U_LMUL, S_U_LA, S_U_P, S_U_LB, S_U_Q,
            S_U_RN, S_U_RD, S_U_RNK, S_U_KG, S_U_RDM:
            begin
                case (state_reg)
                    S_U_LDG:  cmd.sel = SEL_L_DIV_G;
                    S_U_LMUL: begin cmd.sel = SEL_L_MUL; cmd.is_mul = 1'b1; end
                    S_U_LA:   cmd.sel = SEL_LA;
                    S_U_P:    begin cmd.sel = SEL_P; cmd.is_mul = 1'b1; end
                    S_U_LB:   cmd.sel = SEL_LB;
                    S_U_Q:    begin cmd.sel = SEL_Q; cmd.is_mul = 1'b1; end
                    S_U_RN:   cmd.sel = SEL_RN_DIV_G;
                    S_U_RD:   cmd.sel = SEL_RD_DIV_G;
                    S_U_RNK:  cmd.sel = SEL_RN_DIV_G;
                    S_U_KG:   cmd.sel = SEL_K_DIV_G;
                    S_U_RDM:  begin cmd.sel = SEL_RD_MUL; cmd.is_mul = 1'b1; end
                    default:  cmd.sel = SEL_L_DIV_G;
                endcase
                if (!run_reg)
                begin
                    cmd.cmd  = CMD_START;
                    run_next = 1'b1;
                end
                else if (stat.unit_done)
                begin
                    cmd.cmd  = CMD_SAVE;
                    run_next = 1'b0;
                    case (state_reg)
                        S_U_LDG:  state_next = S_U_LMUL;
                        S_U_LMUL: state_next = S_U_LA;
                        S_U_LA:   state_next = S_U_P;
                        S_U_P:    state_next = S_U_LB;
                        S_U_LB:   state_next = S_U_Q;
                        S_U_Q:    begin post_next = 1'b0; state_next = S_RED; end
                        S_U_RN:   state_next = S_U_RD;
                        S_U_RD:   state_next = S_AFTER;
                        S_U_RNK:  state_next = S_U_KG;
                        S_U_KG:   state_next = S_U_RDM;
                        default:  state_next = S_OUT;
                    endcase
                end
            end
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= 1'b0;
            post_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            post_reg  <= post_next;
        end
    end
endmodule

### sv/rational_add_divide_reduce.sv
// channel   dir  payload
// in_ch     in   op, a_num, a_den, b_num, b_den, divisor
// out_ch    out  res_num, res_den, overflow
//
// one request at a time; each divide and multiply runs on the shared bit-serial unit,
// and each euclid remainder is one divide; a request ends soonest on an operand fault,
// or a zero numerator on reduce or divide, and runs longest on add over unequal
// denominators (two gcd chains of up to 45 remainders)
// reset clears the sequencer; the result holds on out_ch until taken
// depends on rad_pkg, rad_if, rad_datapath, rad_ctrl
module rational_add_divide_reduce import rad_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    rad_if.sink   in_ch,
    rad_if.source out_ch
);
    rad_cmd_t  cmd;
    rad_stat_t stat;
    logic [FIELD_BITS-1:0] rn, rd;

    rad_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    rad_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_op(in_ch.data.op), .in_an(in_ch.data.a_num), .in_ad(in_ch.data.a_den),
        .in_bn(in_ch.data.b_num), .in_bd(in_ch.data.b_den), .in_k(in_ch.data.divisor),
        .res_num(rn), .res_den(rd)
    );

    assign out_ch.data.res_num  = rn;
    assign out_ch.data.res_den  = rd;
    assign out_ch.data.overflow = stat.bad;

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.overflow) |->
        (out_ch.data.res_num == '0 && out_ch.data.res_den == FIELD_BITS'(1)))
        else $error("overflow result not 0/1");
    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.res_den != '0) else $error("zero denominator");
endmodule
